>>> src/scp_pkg.sv
// Shared types and codes for the size-class pool allocator.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none
package scp_pkg;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_BULK = 2'd2;
	localparam logic [1:0] ST_OOM  = 2'd3;

	// command kinds from the front part
	localparam logic [1:0] K_NULL  = 2'd0;
	localparam logic [1:0] K_BIG   = 2'd1;
	localparam logic [1:0] K_ALLOC = 2'd2;
	localparam logic [1:0] K_FREE  = 2'd3;

	localparam logic [3:0] MIN_CLASS   = 4'd5;
	localparam logic [3:0] MAX_CLASS   = 4'd12;
	localparam logic [3:0] FIRST_PAGES = 4'd13;
	localparam logic [31:0] POOL_LIMIT  = 32'd4088;
	localparam logic [31:0] USER_OFFSET = 32'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  cls;
		logic [19:0] page;
		logic        in_range;
		logic [6:0]  slot;
	} cmd_t;

endpackage
`default_nettype wire

>>> src/scp_req_if.sv
// Request channel: valid/ready plus one request word.
// Depends on nothing.
`default_nettype none
interface scp_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] request_size;
	logic [31:0] user_address;
	modport source (output valid, action, request_size, user_address, input ready);
	modport sink (input valid, action, request_size, user_address, output ready);
endinterface
`default_nettype wire

>>> src/scp_rsp_if.sv
// Response channel: valid/ready plus one result word.
// Depends on nothing.
`default_nettype none
interface scp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [3:0]  size_class;
	modport source (output valid, status, result_address, size_class, input ready);
	modport sink (input valid, status, result_address, size_class, output ready);
endinterface
`default_nettype wire

>>> src/scp_cfg_if.sv
// Configuration write channel for the heap base register.
// Depends on nothing.
`default_nettype none
interface scp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> src/scp_front.sv
// Front part: holds heap_base, accepts requests and classifies them into commands.
// Depends on scp_pkg and the request/config interfaces.
`default_nettype none
module scp_front #(
	parameter int PAGES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	scp_req_if.sink            req,
	scp_cfg_if.sink            cfg,
	input  wire logic          q_full,
	output logic               q_push,
	output scp_pkg::cmd_t      q_data,
	output logic [31:0]        heap_base
);
	logic [31:0] heap_base_q;
	logic [31:0] size_p7;
	logic [31:0] rel;
	logic [3:0]  cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
		end else if (cfg.valid) begin
			heap_base_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;
	assign heap_base = heap_base_q;
	assign req.ready = !q_full;
	assign q_push = req.valid && !q_full;

	assign size_p7 = req.request_size + 32'd7;
	assign rel = req.user_address - scp_pkg::USER_OFFSET - heap_base_q;

	// bit length of size+7, floor at the smallest class
	always_comb begin
		cls = scp_pkg::MIN_CLASS;
		for (int b = 5; b < 12; b++) begin
			if (size_p7[b]) cls = 4'(b + 1);
		end
		if (req.request_size <= 32'd8) cls = scp_pkg::MIN_CLASS;
	end

	always_comb begin
		q_data.cls = '0;
		q_data.page = rel[31:12];
		q_data.in_range = ({12'd0, rel[31:12]} < 32'(PAGES));
		q_data.slot = rel[11:5];
		if (req.action) begin
			q_data.kind = (req.user_address == '0) ? scp_pkg::K_FREE : scp_pkg::K_FREE;
			if (req.user_address == '0) q_data.kind = scp_pkg::K_NULL;
		end else if (req.request_size == '0) begin
			q_data.kind = scp_pkg::K_NULL;
		end else if (req.request_size > scp_pkg::POOL_LIMIT) begin
			q_data.kind = scp_pkg::K_BIG;
		end else begin
			q_data.kind = scp_pkg::K_ALLOC;
			q_data.cls = cls;
		end
	end
endmodule
`default_nettype wire

>>> src/scp_fifo.sv
// Two-entry command queue between the front and back parts.
// Depends on scp_pkg.
`default_nettype none
module scp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire scp_pkg::cmd_t wdata,
	input  wire logic          pop,
	output logic               full,
	output logic               nonempty,
	output scp_pkg::cmd_t      rdata
);
	scp_pkg::cmd_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign full = cnt_q[1];
	assign nonempty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];
endmodule
`default_nettype wire

>>> src/scp_back.sv
// Back part: free lists, page table, link memory, page carving and the result register.
// Depends on scp_pkg and the response interface.
`default_nettype none
module scp_back #(
	parameter int PAGES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire scp_pkg::cmd_t cmd_in,
	output logic               cmd_pop,
	input  wire logic [31:0]   heap_base,
	scp_rsp_if.source          rsp
);
	localparam int PG_W = $clog2(PAGES);
	localparam int SA_W = PG_W + 7;
	localparam int SLOTS = PAGES * 128;
	localparam int SLOT_W = $clog2(SLOTS + 1);
	localparam int NFP_W = $clog2(PAGES + 1);
	localparam logic [SLOT_W-1:0] EMPTY = SLOT_W'(SLOTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_CARVE = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_POP = 3'd4;
	localparam logic [2:0] S_FREE = 3'd5;

	logic [2:0]        state_q;
	logic              started_q;
	logic [NFP_W-1:0]  nfp_q;
	logic [SLOT_W-1:0] head_q [8];
	scp_pkg::cmd_t     cmd_q;
	logic [3:0]        sp_q;
	logic [PG_W-1:0]   cpage_q;
	logic [3:0]        ccls_q;
	logic [7:0]        off_q;
	logic              ret_start_q;
	logic              out_v_q;
	logic [1:0]        out_st_q;
	logic [31:0]       out_addr_q;
	logic [3:0]        out_cls_q;

	logic [SLOT_W-1:0] slot_mem [SLOTS];
	logic [3:0]        pc_mem [PAGES];
	logic [SLOT_W-1:0] sl_rd_q;
	logic [3:0]        pc_rd_q;

	logic              go;
	logic              out_set;
	logic [2:0]        li;
	logic [SLOT_W-1:0] hd;
	logic [7:0]        step;
	logic [7:0]        nxt;
	logic              last;
	logic [3:0]        fc;
	logic              fc_ok;
	logic [7:0]        fmask;
	logic [SA_W-1:0]   fslot;
	logic              sl_we;
	logic [SA_W-1:0]   sl_wa;
	logic [SLOT_W-1:0] sl_wd;
	logic              pc_we;
	logic [PG_W-1:0]   pc_wa;
	logic [3:0]        pc_wd;
	logic              page_ok;

	assign go = (state_q == S_IDLE) && cmd_valid && (!out_v_q || rsp.ready);
	assign cmd_pop = go;
	assign li = 3'(cmd_q.cls - scp_pkg::MIN_CLASS);
	assign hd = head_q[li];
	assign step = 8'd1 << (ccls_q - scp_pkg::MIN_CLASS);
	assign nxt = off_q + step;
	assign last = nxt[7];
	assign fc = pc_rd_q;
	assign fc_ok = (fc >= scp_pkg::MIN_CLASS) && (fc <= scp_pkg::MAX_CLASS);
	assign fmask = ~((8'd1 << (fc - scp_pkg::MIN_CLASS)) - 8'd1);
	assign fslot = {cmd_q.page[PG_W-1:0], cmd_q.slot & fmask[6:0]};
	assign page_ok = cmd_in.in_range && (cmd_in.page < 20'(nfp_q));

	// load a result word this cycle
	assign out_set = (go && (cmd_in.kind == scp_pkg::K_NULL
			|| (cmd_in.kind == scp_pkg::K_FREE && !page_ok)
			|| (cmd_in.kind == scp_pkg::K_BIG && started_q)))
		|| (state_q == S_CARVE && last && ret_start_q && sp_q == scp_pkg::MAX_CLASS
			&& cmd_q.kind != scp_pkg::K_ALLOC)
		|| (state_q == S_ALLOC && hd >= EMPTY && nfp_q >= NFP_W'(PAGES))
		|| (state_q == S_POP) || (state_q == S_FREE);

	always_comb begin
		sl_we = 1'b0;
		sl_wa = {cpage_q, off_q[6:0]};
		sl_wd = last ? EMPTY : SLOT_W'({cpage_q, nxt[6:0]});
		pc_we = 1'b0;
		pc_wa = cpage_q;
		pc_wd = ccls_q;
		if (state_q == S_CARVE) begin
			sl_we = 1'b1;
			pc_we = 1'b1;
		end else if (state_q == S_START && sp_q < scp_pkg::MIN_CLASS) begin
			pc_we = 1'b1;
			pc_wa = PG_W'(sp_q);
			pc_wd = '0;
		end else if (state_q == S_FREE && fc_ok) begin
			sl_we = 1'b1;
			sl_wa = fslot;
			sl_wd = head_q[3'(fc - scp_pkg::MIN_CLASS)];
		end
	end

	always_ff @(posedge clk) begin
		if (sl_we) slot_mem[sl_wa] <= sl_wd;
		sl_rd_q <= slot_mem[hd[SA_W-1:0]];
		if (pc_we) pc_mem[pc_wa] <= pc_wd;
		pc_rd_q <= pc_mem[cmd_in.page[PG_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (go) cmd_q <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
			nfp_q <= '0;
			for (int i = 0; i < 8; i++) head_q[i] <= EMPTY;
			sp_q <= '0;
			cpage_q <= '0;
			ccls_q <= '0;
			off_q <= '0;
			ret_start_q <= 1'b0;
			out_v_q <= 1'b0;
			out_st_q <= '0;
			out_addr_q <= '0;
			out_cls_q <= '0;
		end else begin
			if (out_set) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						unique case (cmd_in.kind)
							scp_pkg::K_NULL: begin
								out_st_q <= scp_pkg::ST_NULL;
								out_addr_q <= '0;
								out_cls_q <= '0;
							end
							scp_pkg::K_FREE: begin
								if (page_ok) begin
									state_q <= S_FREE;
								end else begin
									out_st_q <= scp_pkg::ST_BULK;
									out_addr_q <= '0;
									out_cls_q <= '0;
								end
							end
							default: begin
								if (!started_q) begin
									sp_q <= '0;
									state_q <= S_START;
								end else if (cmd_in.kind == scp_pkg::K_BIG) begin
									out_st_q <= scp_pkg::ST_BULK;
									out_addr_q <= '0;
									out_cls_q <= '0;
								end else begin
									state_q <= S_ALLOC;
								end
							end
						endcase
					end
				end
				S_START: begin
					if (sp_q < scp_pkg::MIN_CLASS) begin
						sp_q <= sp_q + 4'd1;
					end else begin
						cpage_q <= PG_W'(sp_q);
						ccls_q <= sp_q;
						off_q <= '0;
						ret_start_q <= 1'b1;
						state_q <= S_CARVE;
					end
				end
				S_CARVE: begin
					off_q <= nxt;
					if (last) begin
						head_q[3'(ccls_q - scp_pkg::MIN_CLASS)] <= SLOT_W'({cpage_q, 7'd0});
						if (!ret_start_q) begin
							state_q <= S_ALLOC;
						end else if (sp_q == scp_pkg::MAX_CLASS) begin
							started_q <= 1'b1;
							nfp_q <= NFP_W'(scp_pkg::FIRST_PAGES);
							if (cmd_q.kind == scp_pkg::K_ALLOC) begin
								state_q <= S_ALLOC;
							end else begin
								state_q <= S_IDLE;
								out_st_q <= scp_pkg::ST_BULK;
								out_addr_q <= '0;
								out_cls_q <= '0;
							end
						end else begin
							sp_q <= sp_q + 4'd1;
							state_q <= S_START;
						end
					end
				end
				S_ALLOC: begin
					if (hd >= EMPTY) begin
						if (nfp_q < NFP_W'(PAGES)) begin
							cpage_q <= nfp_q[PG_W-1:0];
							ccls_q <= cmd_q.cls;
							off_q <= '0;
							ret_start_q <= 1'b0;
							nfp_q <= nfp_q + 1'b1;
							state_q <= S_CARVE;
						end else begin
							state_q <= S_IDLE;
							out_st_q <= scp_pkg::ST_OOM;
							out_addr_q <= '0;
							out_cls_q <= cmd_q.cls;
						end
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					head_q[li] <= sl_rd_q;
					state_q <= S_IDLE;
					out_st_q <= scp_pkg::ST_OK;
					out_addr_q <= heap_base + (32'(hd) << 5) + scp_pkg::USER_OFFSET;
					out_cls_q <= cmd_q.cls;
				end
				S_FREE: begin
					state_q <= S_IDLE;
					if (fc_ok) begin
						head_q[3'(fc - scp_pkg::MIN_CLASS)] <= SLOT_W'(fslot);
						out_st_q <= scp_pkg::ST_OK;
						out_addr_q <= heap_base + (32'(fslot) << 5) + scp_pkg::USER_OFFSET;
						out_cls_q <= fc;
					end else begin
						out_st_q <= scp_pkg::ST_BULK;
						out_addr_q <= '0;
						out_cls_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_st_q;
	assign rsp.result_address = out_addr_q;
	assign rsp.size_class = out_cls_q;
endmodule
`default_nettype wire

>>> src/size_class_pool_allocator.sv
// Top level of the size-class pool allocator: front classifier, command queue, back engine.
// Depends on scp_pkg, the channel interfaces, scp_front, scp_fifo and scp_back.
// An alloc from a non-empty list passes the alloc and pop states of the back engine and a free the
// free state; a null or outside-pool request, or an oversize one once the pool is up, is answered
// from idle. The first nonzero alloc claims pages 0 to 12 and carves classes 5 to 12, one block
// link per cycle; an alloc on an empty list carves a fresh page at one link per cycle. The link
// memory has a single write port. Two queued requests may wait while the back part works.
`default_nettype none
module size_class_pool_allocator #(
	parameter int PAGES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	scp_req_if.sink   req,
	scp_rsp_if.source rsp,
	scp_cfg_if.sink   cfg
);
	logic          q_full;
	logic          q_push;
	logic          q_nonempty;
	logic          q_pop;
	scp_pkg::cmd_t q_wdata;
	scp_pkg::cmd_t q_rdata;
	logic [31:0]   heap_base;

	scp_front #(.PAGES(PAGES)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .cfg(cfg),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata), .heap_base(heap_base)
	);

	scp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata), .pop(q_pop),
		.full(q_full), .nonempty(q_nonempty), .rdata(q_rdata)
	);

	scp_back #(.PAGES(PAGES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_nonempty), .cmd_in(q_rdata),
		.cmd_pop(q_pop), .heap_base(heap_base), .rsp(rsp)
	);
endmodule
`default_nettype wire

>>> tb/size_class_pool_allocator_test.sv
// Self-checking bench for size_class_pool_allocator: random and directed alloc/free words,
// a built-in free-list predictor and an in-order result checker.
// Depends on scp_pkg, size_class_pool_allocator and the scp_req_if, scp_rsp_if and scp_cfg_if interfaces.
`default_nettype none
module size_class_pool_allocator_test;

	localparam int PAGES = 64;
	localparam int SLOTS = PAGES * 128;
	localparam logic [13:0] NO_SLOT = 14'(SLOTS);
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 300;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
		logic [3:0]  cls;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int cycles = 0;
	bit steady = 1'b0;

	scp_req_if req ();
	scp_rsp_if rsp ();
	scp_cfg_if cfg ();

	size_class_pool_allocator #(.PAGES(PAGES)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// pool mirror
	logic [31:0] base_q;
	bit          pool_up;
	logic [6:0]  page_next;
	logic [13:0] heads [8];
	logic [13:0] links [SLOTS];
	logic [3:0]  page_cls [PAGES];

	reply_t      awaited_results[$];
	logic [31:0] live_ptrs[$];

	function automatic logic [3:0] class_for_size(logic [31:0] size);
		logic [31:0] v;
		logic [3:0]  n;
		n = 0;
		if (size <= 32'd8) return scp_pkg::MIN_CLASS;
		v = size + 32'd7;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic void carve(int page, logic [3:0] c);
		int step;
		int count;
		int s;
		step = 1 << (c - scp_pkg::MIN_CLASS);
		count = 128 / step;
		for (int j = 0; j < count; j++) begin
			s = page * 128 + j * step;
			links[s] = (j + 1 < count) ? 14'(s + step) : NO_SLOT;
		end
		heads[c - scp_pkg::MIN_CLASS] = 14'(page * 128);
		page_cls[page] = c;
	endfunction

	function automatic reply_t allocate_or_free(logic act, logic [31:0] size,
			logic [31:0] uaddr);
		reply_t r;
		logic [3:0]  c;
		logic [31:0] rel;
		logic [31:0] page;
		logic [31:0] off;
		logic [13:0] s;
		r = '{status: scp_pkg::ST_OK, addr: 32'd0, cls: 4'd0};
		if (act == ACT_ALLOC) begin
			if (size == 0) begin
				r.status = scp_pkg::ST_NULL;
			end else begin
				if (!pool_up) begin
					for (int p = 0; p < scp_pkg::FIRST_PAGES; p++)
						if (p >= scp_pkg::MIN_CLASS) carve(p, 4'(p));
						else page_cls[p] = 4'd0;
					page_next = 7'(scp_pkg::FIRST_PAGES);
					pool_up = 1'b1;
				end
				if (size > scp_pkg::POOL_LIMIT) begin
					r.status = scp_pkg::ST_BULK;
				end else begin
					c = class_for_size(size);
					r.cls = c;
					if (heads[c - scp_pkg::MIN_CLASS] >= NO_SLOT && page_next < PAGES) begin
						carve(page_next, c);
						page_next++;
					end
					if (heads[c - scp_pkg::MIN_CLASS] >= NO_SLOT) begin
						r.status = scp_pkg::ST_OOM;
					end else begin
						s = heads[c - scp_pkg::MIN_CLASS];
						heads[c - scp_pkg::MIN_CLASS] = links[s];
						r.addr = base_q + {s, 5'd0} + scp_pkg::USER_OFFSET;
					end
				end
			end
		end else if (uaddr == 0) begin
			r.status = scp_pkg::ST_NULL;
		end else begin
			rel = uaddr - scp_pkg::USER_OFFSET - base_q;
			page = rel >> 12;
			if (page >= page_next || page >= PAGES || page_cls[page] < scp_pkg::MIN_CLASS
					|| page_cls[page] > scp_pkg::MAX_CLASS) begin
				r.status = scp_pkg::ST_BULK;
			end else begin
				c = page_cls[page];
				off = rel & 32'hFFF;
				off &= ~((32'd1 << c) - 1);
				s = 14'(page * 128 + (off >> 5));
				links[s] = heads[c - scp_pkg::MIN_CLASS];
				heads[c - scp_pkg::MIN_CLASS] = s;
				r.cls = c;
				r.addr = base_q + {s, 5'd0} + scp_pkg::USER_OFFSET;
			end
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result word with nothing awaited");
				errors++;
			end else begin
				e = awaited_results.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.result_address !== e.addr) begin
					$error("result_address expected %h actual %h", e.addr, rsp.result_address);
					errors++;
				end
				if (rsp.size_class !== e.cls) begin
					$error("size_class expected %0d actual %0d", e.cls, rsp.size_class);
					errors++;
				end
			end
		end
	end

	// receiver backpressure in bursts
	int ready_left = 0;
	always @(negedge clk) begin
		if (steady) begin
			rsp.ready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp.ready <= 1'b0;
			ready_left = $urandom_range(1, 18);
		end else begin
			rsp.ready <= 1'b1;
			ready_left = $urandom_range(1, 40);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_request(logic act, logic [31:0] size, logic [31:0] uaddr);
		reply_t r;
		int idx;
		if (!steady && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.request_size <= size;
		req.user_address <= uaddr;
		// predict now: words are accepted in the order presented
		r = allocate_or_free(act, size, uaddr);
		awaited_results.push_back(r);
		if (act == ACT_ALLOC && r.status == scp_pkg::ST_OK) live_ptrs.push_back(r.addr);
		if (act == ACT_FREE && r.status == scp_pkg::ST_OK) begin
			idx = -1;
			foreach (live_ptrs[i]) if (live_ptrs[i] == r.addr) idx = i;
			if (idx >= 0) live_ptrs.delete(idx);
		end
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		wait (awaited_results.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_heap_base(logic [31:0] value);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		base_q = value;
		live_ptrs.delete();
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_before_pool();
		send_request(ACT_FREE, 32'd0, base_q + 32'd5000);
		send_request(ACT_FREE, 32'd0, 32'd0);
		send_request(ACT_ALLOC, 32'd0, 32'd0);
		send_request(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_classes();
		logic [31:0] p;
		logic [31:0] sizes [11];
		sizes = '{32'd1, 32'd8, 32'd9, 32'd24, 32'd25, 32'd57, 32'd120, 32'd500,
			32'd1000, 32'd2040, 32'd4088};
		// first nonzero alloc goes the bulk path but still starts the pool
		send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_request(ACT_ALLOC, 32'd4089, 32'd0);
		foreach (sizes[i])
			send_request(ACT_ALLOC, sizes[i], 32'd0);
		p = live_ptrs[live_ptrs.size() - 2];
		send_request(ACT_FREE, 32'd0, p + 32'd100);   // misaligned
		send_request(ACT_FREE, 32'd0, p);             // double free
		send_request(ACT_FREE, 32'd0, base_q + 32'd8 + 32'd2 * 4096);  // unused page
		send_request(ACT_FREE, 32'd0, base_q + 32'd8 + 32'd63 * 4096); // unclaimed page
		send_request(ACT_FREE, 32'd0, base_q + 32'd4);  // below pool
		send_request(ACT_ALLOC, 32'd4000, 32'd0);
	endtask

	task automatic test_random(int n);
		int r;
		int k;
		logic [31:0] size;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45 || (r < 80 && live_ptrs.size() == 0)) begin
				size = $urandom_range(1, 1 << $urandom_range(3, 12));
				if (size > scp_pkg::POOL_LIMIT) size = scp_pkg::POOL_LIMIT;
				send_request(ACT_ALLOC, size, $urandom);
			end else if (r < 80) begin
				k = $urandom_range(0, live_ptrs.size() - 1);
				send_request(ACT_FREE, $urandom, live_ptrs[k]);
			end else if (r < 86) begin
				send_request(ACT_ALLOC, ($urandom_range(0, 1) != 0) ? $urandom : 32'd0, $urandom);
			end else if (r < 92) begin
				send_request(ACT_FREE, $urandom, ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
			end else if (live_ptrs.size() != 0) begin
				k = $urandom_range(0, live_ptrs.size() - 1);
				// offset pointers half the time, else a plain free of the live pointer
				send_request(ACT_FREE, $urandom,
					live_ptrs[k] + (($urandom_range(0, 1) != 0) ? $urandom_range(1, 4000) : 0));
			end
		end
	endtask

	task automatic test_out_of_pages();
		while (page_next < PAGES)
			send_request(ACT_ALLOC, 32'd3000, 32'd0);
		for (int i = 0; i < 8; i++) send_request(ACT_ALLOC, 32'd3000, 32'd0);
		for (int c = 5; c <= 12; c++)
			repeat (3) send_request(ACT_ALLOC, 32'd1 << (c - 1), 32'd0);
		repeat (10)
			if (live_ptrs.size() != 0) send_request(ACT_FREE, 32'd0, live_ptrs[0]);
		repeat (10) send_request(ACT_ALLOC, 32'd3000, 32'd0);
	endtask

	initial begin
		req.valid = 1'b0;
		req.action = ACT_ALLOC;
		req.request_size = 32'd0;
		req.user_address = 32'd0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = 32'd0;
		base_q = 32'd0;
		pool_up = 1'b0;
		page_next = 7'd0;
		foreach (heads[i]) heads[i] = NO_SLOT;
		foreach (links[i]) links[i] = 14'd0;
		foreach (page_cls[i]) page_cls[i] = 4'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_before_pool();
		set_heap_base(32'd0);
		test_before_pool();
		test_classes();
		test_random(150);
		set_heap_base(32'hFFFF_FFFF);
		test_random(120);
		set_heap_base($urandom);
		test_random(120);
		set_heap_base(32'h8000_0000);
		steady = 1'b1;
		test_out_of_pages();
		test_random(80);

		wait_idle();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
